>>> rtl/hough_line_accumulator_assert.svh
// assertion macros shared by the hough line accumulator rtl
`ifndef HOUGH_LINE_ACCUMULATOR_ASSERT_SVH
`define HOUGH_LINE_ACCUMULATOR_ASSERT_SVH

// antecedent and consequent checked on the same edge
`define HLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hough line accumulator check failed");

// consequent checked on the edge after the antecedent
`define HLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hough line accumulator check failed");

`endif

>>> rtl/hla_pkg.sv
// constants, request codes and trig table function for the hough line accumulator
`default_nettype none

package hla_pkg;

    localparam int N_THETA_DEF = 256;
    localparam int N_RHO_DEF   = 256;

    localparam int COORD_W   = 16;
    localparam int TRIG_W    = 32;
    localparam int PROD_W    = COORD_W + TRIG_W;
    localparam int OFF_W     = 50;
    localparam int COUNT_W   = 16;
    localparam int IDX_OUT_W = 8;

    localparam logic [COUNT_W-1:0] THR_RESET = 16'd1;

    // angles in q30 radians
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // rho offset of 10 and span of 20, both q40
    localparam logic signed [OFF_W-1:0] RHO_OFFSET = 50'sd10995116277760;
    localparam logic signed [OFF_W-1:0] RHO_SPAN   = 50'sd21990232555520;

    // an in-range offset fits this many bits; span is RHO_DIV * 2^QUO_SHIFT
    localparam int SPAN_W    = 45;
    localparam int SPLIT_W   = 21;
    localparam int QUO_SHIFT = 42;
    localparam int RHO_DIV   = 5;

    // floor(q / 5) as (q * DIV5_MUL) >> DIV5_SHIFT, exact for q below 16384
    localparam int DIV5_MUL   = 13108;
    localparam int DIV5_MUL_W = 14;
    localparam int DIV5_SHIFT = 16;

    localparam int TERMS = 12;
    localparam logic [63:0] SIN_DIV [TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };
    localparam logic [63:0] COS_DIV [TERMS] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef enum logic [1:0] {
        REQ_VOTE  = 2'd0,
        REQ_PEAK  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    // q30 taylor series of sine or cosine, evaluated at elaboration only
    function automatic logic signed [TRIG_W-1:0] trig_q30(input logic [63:0] a,
                                                          input logic sine);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        a2   = (a * a) >> 30;
        term = sine ? a : (64'd1 << 30);
        sum  = signed'(term);
        for (int i = 0; i < TERMS; i++) begin
            prod = (term * a2) >> 30;
            if (sine) begin
                term = prod / SIN_DIV[i];
            end else begin
                term = prod / COS_DIV[i];
            end
            if (i[0]) begin
                sum = sum + signed'(term);
            end else begin
                sum = sum - signed'(term);
            end
        end
        return TRIG_W'(sum);
    endfunction

endpackage

`default_nettype wire

>>> rtl/hough_line_accumulator.sv
// line hough accumulator: vote casting, peak scan and store clear
//
// Input channel (i_in_valid / o_in_ready) takes one request per transfer:
// i_req_type selects vote (uses i_point_x, i_point_y, q10 signed), next peak,
// or clear. Code 3 is taken and ignored. Only a next-peak request produces a
// result, on the output channel (o_out_valid / i_out_ready), held in an
// output register until it is taken; a new request is accepted meanwhile.
// The threshold register is written through i_cfg_we / i_cfg_wdata.
// Sequencing, set by one shared 16x32 multiplier and a store with one read and one write port:
//   vote: per angle, table read, x*cos, y*sin, sum, scale with range check,
//         quotient, bin, store read and store write; the steps after the range check are skipped
//         when rho falls outside the grid
//   next peak: a store read and a compare per cell examined from the cursor, then the output step
//   clear: every cell written, one per cycle
// After reset the block sweeps the store to zero with o_in_ready low; threshold resets to 1.
// If the receiver stalls, a finished peak result waits in its final state
// until the output register frees up.
`default_nettype none
`include "hough_line_accumulator_assert.svh"

module hough_line_accumulator #(
    parameter int N_THETA = hla_pkg::N_THETA_DEF,
    parameter int N_RHO   = hla_pkg::N_RHO_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic signed [15:0] i_point_x,
    input  logic signed [15:0] i_point_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_peak_angle_index,
    output logic [7:0]  o_peak_rho_index,
    output logic [15:0] o_peak_count,
    output logic        o_peak_found,
    output logic        o_scan_done
);
    import hla_pkg::*;

    localparam int NCELLS = N_THETA * N_RHO;
    localparam int ADDR_W = $clog2(NCELLS);
    localparam int CUR_W  = $clog2(NCELLS + 1);
    localparam int TH_W   = $clog2(N_THETA);
    localparam int RHO_W  = $clog2(N_RHO);
    localparam int NR_W   = $clog2(N_RHO + 1);
    localparam int HI_W   = SPAN_W - SPLIT_W + NR_W;
    localparam int LO_W   = SPLIT_W + NR_W;
    localparam int SUM_W  = SPAN_W + NR_W + 1;
    localparam int Q_W    = $clog2(RHO_DIV * N_RHO);
    localparam int DM_W   = Q_W + DIV5_MUL_W;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CLR   = 14'b00000000000010,
        S_TAB   = 14'b00000000000100,
        S_MX    = 14'b00000000001000,
        S_MY    = 14'b00000000010000,
        S_SUM   = 14'b00000000100000,
        S_SCALE = 14'b00000001000000,
        S_QUO   = 14'b00000010000000,
        S_BIN   = 14'b00000100000000,
        S_RD    = 14'b00001000000000,
        S_WR    = 14'b00010000000000,
        S_SRD   = 14'b00100000000000,
        S_SCMP  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } t_state;

    // constant cosine and sine tables, one entry per angle
    logic signed [TRIG_W-1:0] w_cos_tab [N_THETA];
    logic signed [TRIG_W-1:0] w_sin_tab [N_THETA];

    for (genvar g = 0; g < N_THETA; g++) begin : g_trig
        localparam logic [63:0] THETA = (64'(g) * PI_Q30) / N_THETA;
        localparam logic        FLIP  = THETA > HALF_PI_Q30;
        localparam logic [63:0] ANG   = FLIP ? PI_Q30 - THETA : THETA;
        localparam logic signed [TRIG_W-1:0] COS_A = trig_q30(ANG, 1'b0);
        localparam logic signed [TRIG_W-1:0] SIN_A = trig_q30(ANG, 1'b1);
        assign w_cos_tab[g] = FLIP ? -COS_A : COS_A;
        assign w_sin_tab[g] = SIN_A;
    end

    t_state r_state;
    t_state n_state;

    logic [COUNT_W-1:0]       r_thr;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic [TH_W-1:0]          r_t;
    logic [ADDR_W-1:0]        r_base;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic signed [PROD_W-1:0] r_prod_x;
    logic signed [PROD_W-1:0] r_prod_y;
    logic signed [OFF_W-1:0]  r_off;
    logic [HI_W-1:0]          r_p_hi;
    logic [LO_W-1:0]          r_p_lo;
    logic [Q_W-1:0]           r_q;
    logic [ADDR_W-1:0]        r_addr;
    logic [COUNT_W-1:0]       r_rd_data;
    logic [ADDR_W-1:0]        r_clr_addr;
    logic [CUR_W-1:0]         r_cursor;
    logic [TH_W-1:0]          r_cur_t;
    logic [RHO_W-1:0]         r_cur_r;
    logic                     r_pk_found;
    logic [TH_W-1:0]          r_pk_t;
    logic [RHO_W-1:0]         r_pk_r;
    logic [COUNT_W-1:0]       r_pk_cnt;
    logic                     r_out_valid;
    logic [IDX_OUT_W-1:0]     r_out_angle;
    logic [IDX_OUT_W-1:0]     r_out_rho;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_found;
    logic                     r_out_done;

    logic [COUNT_W-1:0]       r_store [NCELLS];

    logic                     w_in_acc;
    logic                     w_out_load;
    logic                     w_last_t;
    logic                     w_in_range;
    logic                     w_next_angle;
    logic                     w_scan_end;
    logic                     w_hit;
    logic signed [COORD_W-1:0] w_mul_a;
    logic signed [TRIG_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_mul;
    logic [HI_W-1:0]          w_p_hi;
    logic [LO_W-1:0]          w_p_lo;
    logic [SUM_W-1:0]         w_sum;
    logic [DM_W-1:0]          w_div;
    logic [RHO_W-1:0]         w_bin;
    logic [COUNT_W-1:0]       w_inc;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [COUNT_W-1:0]       w_wdata;
    logic [ADDR_W-1:0]        w_raddr;

    assign w_in_acc     = (r_state == S_IDLE) && i_in_valid;
    assign w_out_load   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign w_last_t     = (r_t == TH_W'(N_THETA - 1));
    assign w_in_range   = !r_off[OFF_W-1] && (r_off < RHO_SPAN);
    assign w_next_angle = ((r_state == S_SCALE) && !w_in_range) || (r_state == S_WR);
    assign w_scan_end   = (r_cursor == CUR_W'(NCELLS));
    assign w_hit        = (r_rd_data >= r_thr);

    // the one shared multiplier: x*cos, then y*sin
    assign w_mul_a = (r_state == S_MX) ? r_x : r_y;
    assign w_mul_b = (r_state == S_MX) ? r_cos : r_sin;
    assign w_mul   = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // bin = floor(off * N_RHO / (5 * 2^42)), offset split to keep products narrow
    assign w_p_hi = HI_W'(r_off[SPAN_W-1:SPLIT_W]) * HI_W'(N_RHO);
    assign w_p_lo = LO_W'(r_off[SPLIT_W-1:0]) * LO_W'(N_RHO);
    assign w_sum  = (SUM_W'(r_p_hi) << SPLIT_W) + SUM_W'(r_p_lo);
    assign w_div  = DM_W'(r_q) * DM_W'(DIV5_MUL);
    assign w_bin  = w_div[DIV5_SHIFT +: RHO_W];

    assign w_inc  = (r_rd_data == {COUNT_W{1'b1}}) ? r_rd_data : r_rd_data + COUNT_W'(1);

    // store port control
    assign w_we    = (r_state == S_WR) || (r_state == S_CLR);
    assign w_waddr = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign w_wdata = (r_state == S_CLR) ? '0 : w_inc;
    assign w_raddr = (r_state == S_SRD) ? r_cursor[ADDR_W-1:0] : r_addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_store[w_raddr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_req'(i_req_type))
                        REQ_VOTE:  n_state = S_TAB;
                        REQ_PEAK:  n_state = S_SRD;
                        REQ_CLEAR: n_state = S_CLR;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                if (r_clr_addr == ADDR_W'(NCELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_TAB:   n_state = S_MX;
            S_MX:    n_state = S_MY;
            S_MY:    n_state = S_SUM;
            S_SUM:   n_state = S_SCALE;
            S_SCALE: begin
                if (w_in_range) begin
                    n_state = S_QUO;
                end else begin
                    n_state = w_last_t ? S_IDLE : S_TAB;
                end
            end
            S_QUO:   n_state = S_BIN;
            S_BIN:   n_state = S_RD;
            S_RD:    n_state = S_WR;
            S_WR:    n_state = w_last_t ? S_IDLE : S_TAB;
            S_SRD:   n_state = w_scan_end ? S_OUT : S_SCMP;
            S_SCMP:  n_state = w_hit ? S_OUT : S_SRD;
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_thr       <= THR_RESET;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_cur_t     <= '0;
            r_cur_r     <= '0;
            r_t         <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_acc && (t_req'(i_req_type) == REQ_CLEAR)) begin
                r_clr_addr <= '0;
                r_cursor   <= '0;
                r_cur_t    <= '0;
                r_cur_r    <= '0;
            end
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (w_in_acc && (t_req'(i_req_type) == REQ_VOTE)) begin
                r_t    <= '0;
                r_base <= '0;
            end
            if (w_next_angle) begin
                r_t    <= r_t + TH_W'(1);
                r_base <= r_base + ADDR_W'(N_RHO);
            end
            // cursor moves past every cell examined
            if (r_state == S_SCMP) begin
                r_cursor <= r_cursor + CUR_W'(1);
                if (r_cur_r == RHO_W'(N_RHO - 1)) begin
                    r_cur_r <= '0;
                    r_cur_t <= r_cur_t + TH_W'(1);
                end else begin
                    r_cur_r <= r_cur_r + RHO_W'(1);
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_x <= i_point_x;
            r_y <= i_point_y;
        end
        if (r_state == S_TAB) begin
            r_cos <= w_cos_tab[r_t];
            r_sin <= w_sin_tab[r_t];
        end
        if (r_state == S_MX) begin
            r_prod_x <= w_mul;
        end
        if (r_state == S_MY) begin
            r_prod_y <= w_mul;
        end
        if (r_state == S_SUM) begin
            r_off <= OFF_W'(r_prod_x) + OFF_W'(r_prod_y) + RHO_OFFSET;
        end
        if (r_state == S_SCALE) begin
            r_p_hi <= w_p_hi;
            r_p_lo <= w_p_lo;
        end
        if (r_state == S_QUO) begin
            r_q <= w_sum[QUO_SHIFT +: Q_W];
        end
        if (r_state == S_BIN) begin
            r_addr <= r_base + ADDR_W'(w_bin);
        end
        if ((r_state == S_SCMP) && w_hit) begin
            r_pk_found <= 1'b1;
            r_pk_t     <= r_cur_t;
            r_pk_r     <= r_cur_r;
            r_pk_cnt   <= r_rd_data;
        end
        if ((r_state == S_SRD) && w_scan_end) begin
            r_pk_found <= 1'b0;
            r_pk_t     <= '0;
            r_pk_r     <= '0;
            r_pk_cnt   <= '0;
        end
        if (w_out_load) begin
            r_out_angle <= IDX_OUT_W'(r_pk_t);
            r_out_rho   <= IDX_OUT_W'(r_pk_r);
            r_out_count <= r_pk_cnt;
            r_out_found <= r_pk_found;
            r_out_done  <= !r_pk_found;
        end
    end

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_peak_angle_index = r_out_angle;
    assign o_peak_rho_index   = r_out_rho;
    assign o_peak_count       = r_out_count;
    assign o_peak_found       = r_out_found;
    assign o_scan_done        = r_out_done;

    `HLA_ASSERT_NEXT(a_cursor_step, i_clk, i_rst_n, (r_state == S_SCMP), (r_cursor == $past(r_cursor) + CUR_W'(1)))
    `HLA_ASSERT_SAME(a_vote_in_row, i_clk, i_rst_n, (r_state == S_RD), (ADDR_W'(r_addr - r_base) < ADDR_W'(N_RHO)))
    `HLA_ASSERT_SAME(a_out_from_final, i_clk, i_rst_n, $rose(r_out_valid), ($past(r_state) == S_OUT))
    `HLA_ASSERT_SAME(a_found_xor_done, i_clk, i_rst_n, r_out_valid, (r_out_found != r_out_done))

endmodule

`default_nettype wire

>>> verif/tb_hough_line_accumulator.sv
// self-checking testbench for the hough line accumulator: votes, peak scan, clear
`timescale 1ns / 100ps

module tb_hough_line_accumulator;
    import hla_pkg::*;

    localparam int N_ANG   = 256;
    localparam int N_BINS  = 256;
    localparam int N_CELLS = N_ANG * N_BINS;

    localparam longint unsigned ANGLE_PI_Q30   = 64'd3373259426;
    localparam longint unsigned ANGLE_HALF_Q30 = 64'd1686629713;
    localparam longint ONE_Q40      = 64'sd1099511627776;
    localparam longint RHO_HALF_Q40 = 10 * ONE_Q40;
    localparam longint RHO_SPAN_Q40 = 20 * ONE_Q40;

    localparam logic [1:0]  REQ_RESERVED = 2'd3;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;
    // points within 7 units of the origin keep rho inside the grid at every angle
    localparam int GRID_Q10     = 7168;
    localparam int ITEMS_TARGET = 1150;
    localparam int QUIET_TAIL   = 150;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
    } t_hough_req;

    typedef struct packed {
        logic [7:0]  angle;
        logic [7:0]  rho_bin;
        logic [15:0] count;
        logic        found;
        logic        done;
    } t_peak_report;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_wdata;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_req_type;
    logic signed [15:0] i_point_x;
    logic signed [15:0] i_point_y;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [7:0]         o_peak_angle_index;
    logic [7:0]         o_peak_rho_index;
    logic [15:0]        o_peak_count;
    logic               o_peak_found;
    logic               o_scan_done;

    // accumulator image kept alongside the block
    longint       cos_q30 [N_ANG];
    longint       sin_q30 [N_ANG];
    logic [15:0]  vote_cells [N_CELLS];
    int unsigned  scan_pos;
    logic [15:0]  peak_threshold;

    t_hough_req   pending_reqs [$];
    t_peak_report expected_peaks [$];
    t_hough_req   in_flight;
    int unsigned  queued_total;
    int unsigned  accepted_total;
    int unsigned  stim_items;
    int unsigned  mismatch_count;
    int unsigned  send_gap;
    int unsigned  stall_left;
    bit           idling_on;

    hough_line_accumulator #(
        .N_THETA(N_ANG),
        .N_RHO  (N_BINS)
    ) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // q30 sine or cosine series, twelve correction terms
    function automatic longint taylor_q30(longint unsigned a, bit sine_series);
        longint unsigned sq;
        longint unsigned term;
        longint unsigned k;
        longint          sum;
        sq   = (a * a) >> 30;
        term = sine_series ? a : (64'd1 << 30);
        k    = sine_series ? 64'd2 : 64'd1;
        sum  = longint'(term);
        for (int n = 0; n < 12; n++) begin
            term = ((term * sq) >> 30) / (k * (k + 64'd1));
            k    = k + 64'd2;
            if (n % 2 == 1) begin
                sum = sum + longint'(term);
            end else begin
                sum = sum - longint'(term);
            end
        end
        return sum;
    endfunction

    function automatic void clear_cells();
        foreach (vote_cells[i]) vote_cells[i] = '0;
        scan_pos = 0;
    endfunction

    function automatic void cast_votes(logic signed [15:0] px, logic signed [15:0] py);
        longint rho;
        longint offset;
        longint bin;
        for (int t = 0; t < N_ANG; t++) begin
            rho    = longint'(px) * cos_q30[t] + longint'(py) * sin_q30[t];
            offset = rho + RHO_HALF_Q40;
            bin    = offset * N_BINS / RHO_SPAN_Q40;
            // rho of exactly +10 lands one past the last bin and is dropped
            if (offset >= 0 && bin < N_BINS && vote_cells[t * N_BINS + bin] != COUNT_MAX) begin
                vote_cells[t * N_BINS + bin] = vote_cells[t * N_BINS + bin] + 16'd1;
            end
        end
    endfunction

    function automatic t_peak_report next_peak();
        t_peak_report rep;
        rep = '0;
        while (scan_pos < N_CELLS && vote_cells[scan_pos] < peak_threshold) scan_pos++;
        if (scan_pos < N_CELLS) begin
            rep.angle   = 8'(scan_pos / N_BINS);
            rep.rho_bin = 8'(scan_pos % N_BINS);
            rep.count   = vote_cells[scan_pos];
            rep.found   = 1'b1;
            scan_pos++;
        end else begin
            rep.done = 1'b1;
        end
        return rep;
    endfunction

    function automatic void report_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function automatic void push_req(logic [1:0] kind, int x, int y);
        t_hough_req req;
        req.kind = kind;
        req.x    = 16'(x);
        req.y    = 16'(y);
        pending_reqs = {pending_reqs, req};
        queued_total++;
        if (kind != REQ_RESERVED) stim_items++;
    endfunction

    // an occasional unused code slips in ahead of a vote
    function automatic void push_vote(int x, int y);
        if ($urandom_range(0, 11) == 0) push_req(REQ_RESERVED, $urandom, $urandom);
        push_req(REQ_VOTE, x, y);
    endfunction

    function automatic int grid_coord();
        return int'($urandom_range(0, 2 * GRID_Q10)) - GRID_Q10;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    task automatic wait_idle();
        while (accepted_total != queued_total || expected_peaks.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        peak_threshold = value;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            // the image follows requests in transfer order
            if (i_in_valid && o_in_ready) begin
                accepted_total++;
                case (in_flight.kind)
                    REQ_VOTE:  cast_votes(in_flight.x, in_flight.y);
                    REQ_PEAK:  expected_peaks = {expected_peaks, next_peak()};
                    REQ_CLEAR: clear_cells();
                    default:   ;
                endcase
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap == 0 && idling_on && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 9);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_flight = pending_reqs.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= in_flight.kind;
                    i_point_x  <= in_flight.x;
                    i_point_y  <= in_flight.y;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // peak report monitor
    always @(posedge i_clk) begin : peak_monitor
        t_peak_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_peaks.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: expected no peak report, got angle %0d rho %0d",
                             $time, o_peak_angle_index, o_peak_rho_index);
                    $display("    count %0d found %0b done %0b",
                             o_peak_count, o_peak_found, o_scan_done);
                end else begin
                    want = expected_peaks.pop_front();
                    report_field("peak_angle_index", want.angle, o_peak_angle_index);
                    report_field("peak_rho_index", want.rho_bin, o_peak_rho_index);
                    report_field("peak_count", want.count, o_peak_count);
                    report_field("peak_found", want.found, o_peak_found);
                    report_field("scan_done", want.done, o_scan_done);
                end
            end
            if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned     roll;
        int unsigned     n_votes;
        int unsigned     n_peaks;
        int              line_ang;
        longint          line_rho;
        longint          along;
        int              px;
        int              py;
        longint unsigned theta;
        longint unsigned ang;
        logic [15:0]     thr;

        // past a quarter turn the mirrored angle is used and cos flips sign
        for (int t = 0; t < N_ANG; t++) begin
            theta      = longint'(t) * ANGLE_PI_Q30 / N_ANG;
            ang        = (theta > ANGLE_HALF_Q30) ? ANGLE_PI_Q30 - theta : theta;
            cos_q30[t] = (theta > ANGLE_HALF_Q30) ? -taylor_q30(ang, 1'b0)
                                                  : taylor_q30(ang, 1'b0);
            sin_q30[t] = taylor_q30(ang, 1'b1);
        end

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_VOTE;
        i_point_x      = '0;
        i_point_y      = '0;
        i_out_ready    = 1'b0;
        idling_on      = 1'b1;
        queued_total   = 0;
        accepted_total = 0;
        stim_items     = 0;
        mismatch_count = 0;
        peak_threshold = THR_RESET;
        clear_cells();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // threshold still at its reset value
        push_req(REQ_VOTE, 0, 0);
        push_req(REQ_VOTE, 32767, -32768);
        push_req(REQ_VOTE, -32768, 32767);
        push_req(REQ_VOTE, 10240, 0);       // rho exactly +10 at angle 0, dropped
        push_req(REQ_VOTE, -10240, 0);      // rho exactly -10 at angle 0, lowest bin
        push_req(REQ_VOTE, 0, -10240);
        push_req(REQ_RESERVED, -1, -1);
        repeat (4) push_req(REQ_PEAK, 0, 0);
        wait_idle();

        // zero threshold: every remaining cell qualifies, empty ones too
        set_threshold(16'd0);
        repeat (2) push_req(REQ_PEAK, 0, 0);
        push_req(REQ_CLEAR, 0, 0);
        repeat (2) push_req(REQ_PEAK, 0, 0);
        wait_idle();

        // nothing qualifies, then the cursor sits at the end
        set_threshold(COUNT_MAX);
        push_req(REQ_VOTE, 0, 0);
        repeat (3) push_req(REQ_PEAK, 0, 0);
        wait_idle();

        set_threshold(16'd2);
        push_req(REQ_CLEAR, 0, 0);
        repeat (2) push_req(REQ_VOTE, 512, -512);
        push_req(REQ_VOTE, 0, 0);
        repeat (2) push_req(REQ_PEAK, 0, 0);
        wait_idle();

        while (stim_items < ITEMS_TARGET) begin
            idling_on = (stim_items + QUIET_TAIL < ITEMS_TARGET) && ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 19);
            if (roll < 10) begin
                thr = 16'd1;
            end else if (roll < 14) begin
                thr = 16'd2;
            end else if (roll < 16) begin
                thr = 16'($urandom_range(3, 6));
            end else if (roll == 16) begin
                thr = 16'd0;
            end else if (roll == 17) begin
                thr = COUNT_MAX;
            end else begin
                thr = 16'($urandom_range(0, 65535));
            end
            set_threshold(thr);

            if ($urandom_range(0, 2) != 0) push_req(REQ_CLEAR, $urandom, $urandom);
            n_votes = $urandom_range(4, 24);
            case ($urandom_range(0, 3))
                0: begin
                    // points on one line pile up in the cell of that line
                    line_ang = $urandom_range(0, N_ANG - 1);
                    line_rho = longint'($urandom_range(0, 12288)) - 6144;
                    for (int i = 0; i < n_votes; i++) begin
                        along = longint'($urandom_range(0, 2 * GRID_Q10)) - GRID_Q10;
                        px = int'((line_rho * cos_q30[line_ang]
                                   - along * sin_q30[line_ang]) >>> 30);
                        py = int'((line_rho * sin_q30[line_ang]
                                   + along * cos_q30[line_ang]) >>> 30);
                        push_vote(px, py);
                    end
                end
                1: begin
                    px = grid_coord();
                    py = grid_coord();
                    repeat ($urandom_range(2, 8)) push_vote(px, py);
                end
                2: begin
                    for (int i = 0; i < n_votes; i++) push_vote(grid_coord(), grid_coord());
                end
                default: begin
                    // full range, mostly off the grid
                    for (int i = 0; i < n_votes / 2; i++) push_vote(full_coord(), full_coord());
                end
            endcase

            n_peaks = $urandom_range(1, 16);
            for (int i = 0; i < n_peaks; i++) begin
                if (i > 0 && $urandom_range(0, 5) == 0) push_vote(grid_coord(), grid_coord());
                push_req(REQ_PEAK, $urandom, $urandom);
            end
            wait_idle();
        end

        // a vote's worth of cycles so a stray report still shows up
        repeat (2400) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> hough_line_accumulator.f
+incdir+rtl
rtl/hla_pkg.sv
rtl/hough_line_accumulator.sv
verif/tb_hough_line_accumulator.sv
